// ===== sv/fractal_value_noise_sampler_unit_assert.svh =====
// assertion macros shared by the checker
`ifndef FRACTAL_VALUE_NOISE_SAMPLER_UNIT_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_SAMPLER_UNIT_ASSERT_SVH

// implication checked on every edge outside reset
`define FVN_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// implication checked in the next cycle
`define FVN_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// ===== sv/fvn_pkg.sv =====
package fvn_pkg;
  localparam int MaxRowsDef    = 64;
  localparam int MaxColsDef    = 64;
  localparam int MaxOctavesDef = 8;
  localparam int SampleBitsDef = 16;

  localparam logic [6:0] RowsReset    = 7'd64;
  localparam logic [6:0] ColsReset    = 7'd64;
  localparam logic [3:0] OctavesReset = 4'd6;

  localparam logic [1:0] RegRows    = 2'd0;
  localparam logic [1:0] RegCols    = 2'd1;
  localparam logic [1:0] RegOctaves = 2'd2;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [7:0] GrayBase  = 8'd100;
  localparam logic [6:0] GrayScale = 7'd80;
endpackage

// ===== sv/fractal_value_noise_sampler_unit.sv =====
// channel | direction | handshake                            | payload
// input   | in        | start && !busy                       | in_operation, in_row, in_col, in_sample
// result  | out       | out_valid, one cycle                 | out_noise_value, out_gray_level
// config  | in/out    | psel && penable && pwrite && pready  | paddr, pwdata, prdata
//
// a load is written at its accept edge and leaves busy low
// a query holds busy through setup (row/rows and col/cols wrap subtractions), then per
// octave an address step, the corner wraps and four corner reads behind the registered
// read data, and an accumulate; then two restoring divides (one quotient bit a cycle)
// and an output state
// result strobe comes in the same cycle as busy falls; it cannot be stalled
// reset is synchronous active low; the grid memory is not cleared
module fractal_value_noise_sampler_unit #(
  parameter int MAX_ROWS    = fvn_pkg::MaxRowsDef,
  parameter int MAX_COLS    = fvn_pkg::MaxColsDef,
  parameter int MAX_OCTAVES = fvn_pkg::MaxOctavesDef,
  parameter int SAMPLE_BITS = fvn_pkg::SampleBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [5:0]  in_row,
  input  logic [5:0]  in_col,
  input  logic [15:0] in_sample,
  output logic        out_valid,
  output logic [15:0] out_noise_value,
  output logic [7:0]  out_gray_level,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int Depth    = MAX_ROWS * MAX_COLS;
  localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int OctBits  = $clog2(MAX_OCTAVES + 1);
  // sum bound: sample * 2^(n-1) * (2^n-1) plus room
  localparam int AccBits  = SAMPLE_BITS + 3 * MAX_OCTAVES + 1;
  // gray numerator gets *80 (7 bits)
  localparam int GnBits   = AccBits + 7;
  localparam int DenBits  = 2 * MAX_OCTAVES + SAMPLE_BITS;
  localparam int CntBits  = $clog2(GnBits + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_ADDR, S_CORNER, S_ACC, S_DIV_NV, S_DIV_GR, S_OUT
  } state_t;

  // configuration registers
  logic [6:0] grid_rows_r, grid_cols_r;
  logic [3:0] octave_count_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r    <= fvn_pkg::RowsReset;
      grid_cols_r    <= fvn_pkg::ColsReset;
      octave_count_r <= fvn_pkg::OctavesReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        fvn_pkg::RegRows:    grid_rows_r    <= pwdata[6:0];
        fvn_pkg::RegCols:    grid_cols_r    <= pwdata[6:0];
        fvn_pkg::RegOctaves: octave_count_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      fvn_pkg::RegRows:    prdata[6:0] = grid_rows_r;
      fvn_pkg::RegCols:    prdata[6:0] = grid_cols_r;
      fvn_pkg::RegOctaves: prdata[3:0] = octave_count_r;
      default:             prdata      = '0;
    endcase
  end

  // saturated settings
  logic [10:0] rows_sat, cols_sat;
  logic [OctBits-1:0] n_sat;
  always_comb begin
    if (grid_rows_r == 7'd0) rows_sat = 11'd1;
    else if (32'(grid_rows_r) > MAX_ROWS) rows_sat = 11'(MAX_ROWS);
    else rows_sat = 11'(grid_rows_r);
    if (grid_cols_r == 7'd0) cols_sat = 11'd1;
    else if (32'(grid_cols_r) > MAX_COLS) cols_sat = 11'(MAX_COLS);
    else cols_sat = 11'(grid_cols_r);
    if (octave_count_r == 4'd0) n_sat = OctBits'(1);
    else if (32'(octave_count_r) > MAX_OCTAVES) n_sat = OctBits'(MAX_OCTAVES);
    else n_sat = OctBits'(octave_count_r);
  end

  state_t state_r;
  logic [10:0] r_r, c_r;            // reduced coordinates
  logic [OctBits-1:0] n_r, k_r;
  logic [1:0]  corner_r;
  logic [10:0] r0_r, r1_r, c0_r, c1_r;
  logic [11:0] p_r;
  logic [AccBits-1:0] acc_r, blend_r;
  logic [GnBits-1:0]  rem_r, quo_r, num_r;
  logic [DenBits-1:0] den_r;
  logic [CntBits-1:0] cnt_r;
  logic        rd_pend_r;
  logic        out_valid_r;
  logic [15:0] nv_r;
  logic [7:0]  gray_r;
  logic [23:0] wt_r;

  // memory
  logic                 wr_en;
  logic [AddrBits-1:0]  wr_addr, rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [10:0] rd_row, rd_col;

  assign wr_en   = start && !busy && (in_operation == fvn_pkg::OpLoad) &&
                   (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
  assign wr_addr = AddrBits'(32'(in_row) * MAX_COLS + 32'(in_col));
  assign rd_row  = corner_r[0] ? r1_r : r0_r;
  assign rd_col  = corner_r[1] ? c1_r : c0_r;
  assign rd_addr = AddrBits'(32'(rd_row) * MAX_COLS + 32'(rd_col));

  fvn_ram #(.Width(SAMPLE_BITS), .Depth(Depth)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr),
    .wr_data(SAMPLE_BITS'(in_sample)), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // corner weight for the address being read, registered so it lines up with the data
  logic [11:0] fr, fc, wr_w, wc_w;
  logic [23:0] wt;
  logic [SAMPLE_BITS+23:0] prod_full;
  logic [AccBits-1:0] prod;
  assign fr   = 12'(r_r) & (p_r - 12'd1);
  assign fc   = 12'(c_r) & (p_r - 12'd1);
  assign wr_w = corner_r[0] ? fr : (p_r - fr);
  assign wc_w = corner_r[1] ? fc : (p_r - fc);
  assign wt   = wr_w * wc_w;
  assign prod_full = rd_data * wt_r;              // the shared multiplier
  assign prod      = AccBits'(prod_full);

  // restoring divider step
  logic [GnBits:0] trial;
  assign trial = {rem_r, quo_r[GnBits-1]} - (GnBits+1)'(den_r);

  assign busy     = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_noise_value = nv_r;
  assign out_gray_level  = gray_r;

  logic [10:0] r0_nxt, c0_nxt, r1s, c1s;
  assign r0_nxt = r_r & ~(p_r[10:0] - 11'd1);
  assign c0_nxt = c_r & ~(p_r[10:0] - 11'd1);
  assign r1s    = r0_nxt + p_r[10:0];
  assign c1s    = c0_nxt + p_r[10:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_OUT);
      wt_r        <= wt;
      unique case (state_r)
        S_IDLE: begin
          if (start && in_operation == fvn_pkg::OpQuery) begin
            r_r     <= 11'(in_row);
            c_r     <= 11'(in_col);
            n_r     <= n_sat;
            acc_r   <= '0;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          // reduce coordinates by repeated subtraction
          if (r_r >= rows_sat) r_r <= r_r - rows_sat;
          else if (c_r >= cols_sat) c_r <= c_r - cols_sat;
          else begin
            k_r     <= '0;
            p_r     <= 12'd1;
            state_r <= S_ADDR;
          end
        end
        S_ADDR: begin
          // corner positions; wrap by subtract (r0+p may exceed rows many times
          // only when p > rows, then r0 is zero and we reduce iteratively)
          r0_r <= r0_nxt;
          c0_r <= c0_nxt;
          r1_r <= r1s;
          c1_r <= c1s;
          corner_r  <= 2'd0;
          blend_r   <= '0;
          rd_pend_r <= 1'b0;
          state_r   <= S_CORNER;
        end
        S_CORNER: begin
          if (r1_r >= rows_sat) r1_r <= r1_r - rows_sat;
          else if (c1_r >= cols_sat) c1_r <= c1_r - cols_sat;
          else begin
            if (rd_pend_r) blend_r <= blend_r + prod;
            rd_pend_r <= 1'b1;
            corner_r  <= corner_r + 2'd1;
            if (rd_pend_r && corner_r == 2'd0) begin
              state_r <= S_ACC;
            end
          end
        end
        S_ACC: begin
          acc_r <= acc_r + (blend_r << (n_r - 1'b1 - k_r));
          if (k_r + 1'b1 == n_r) begin
            num_r <= GnBits'(acc_r + (blend_r << (n_r - 1'b1 - k_r)));
            quo_r <= GnBits'(acc_r + (blend_r << (n_r - 1'b1 - k_r)));
            den_r <= DenBits'(((2 ** MAX_OCTAVES) - 1) & ((1 << n_r) - 1))
                     << (n_r - 1'b1);
            rem_r <= '0;
            cnt_r <= CntBits'(GnBits);
            state_r <= S_DIV_NV;
          end else begin
            k_r     <= k_r + 1'b1;
            p_r     <= p_r << 1;
            state_r <= S_ADDR;
          end
        end
        S_DIV_NV, S_DIV_GR: begin
          if (cnt_r != '0) begin
            if (!trial[GnBits]) begin
              rem_r <= trial[GnBits-1:0];
              quo_r <= {quo_r[GnBits-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[GnBits-2:0], quo_r[GnBits-1]};
              quo_r <= {quo_r[GnBits-2:0], 1'b0};
            end
            cnt_r <= cnt_r - 1'b1;
          end else if (state_r == S_DIV_NV) begin
            nv_r  <= quo_r[15:0];
            quo_r <= GnBits'(num_r * fvn_pkg::GrayScale);
            den_r <= den_r << SAMPLE_BITS;
            rem_r <= '0;
            cnt_r <= CntBits'(GnBits);
            state_r <= S_DIV_GR;
          end else begin
            gray_r  <= fvn_pkg::GrayBase + quo_r[7:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/fvn_ram.sv =====
module fvn_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== sv/fvn_checker.sv =====
`include "fractal_value_noise_sampler_unit_assert.svh"
module fvn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_operation,
  input logic       out_valid,
  input logic [7:0] out_gray_level,
  input logic       pready
);
  `FVN_ASSERT_NXT(a_load_no_busy, clk, rst_n, start && !busy && in_operation == fvn_pkg::OpLoad, !busy)
  `FVN_ASSERT_NXT(a_query_busy, clk, rst_n, start && !busy && in_operation == fvn_pkg::OpQuery, busy)
  `FVN_ASSERT_NXT(a_result_single, clk, rst_n, out_valid, !out_valid)
  `FVN_ASSERT_IMP(a_gray_range, clk, rst_n, out_valid, 8'(out_gray_level - 8'd100) < 8'd80)
  `FVN_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready)
endmodule

bind fractal_value_noise_sampler_unit fvn_checker u_fvn_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_operation(in_operation), .out_valid(out_valid),
  .out_gray_level(out_gray_level), .pready(pready)
);

// ===== verif/tb_fractal_value_noise_sampler_unit.sv =====
module tb_fractal_value_noise_sampler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GridDepth    = fvn_pkg::MaxRowsDef * fvn_pkg::MaxColsDef;
  // sampled area: every entry here is written before any query, and no
  // register setting used below makes a query read outside it
  localparam int FillRows     = 32;
  localparam int FillCols     = 32;
  // idle gap after the last result, before a register write or the end
  localparam int DrainCycles  = 300;
  localparam int StallLimit   = 5000;

  typedef struct packed {
    logic [15:0] noise_value;
    logic [7:0]  gray_level;
  } noise_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [5:0]  in_row;
  logic [5:0]  in_col;
  logic [15:0] in_sample;
  logic        out_valid;
  logic [15:0] out_noise_value;
  logic [7:0]  out_gray_level;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // own copy of the grid and the registers, updated as transactions are accepted
  logic [15:0]   grid_model [GridDepth];
  logic [6:0]    rows_reg;
  logic [6:0]    cols_reg;
  logic [3:0]    octaves_reg;
  noise_result_t pending_noise [$];
  int            mismatches;
  int            sender_idle_pct;
  int            stall_cycles;

  fractal_value_noise_sampler_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_row(in_row), .in_col(in_col), .in_sample(in_sample),
    .out_valid(out_valid), .out_noise_value(out_noise_value),
    .out_gray_level(out_gray_level),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // fractal noise of one pixel from the modelled grid and registers
  function automatic noise_result_t fractal_noise(input logic [5:0] row,
                                                  input logic [5:0] col);
    int unsigned   rows, cols, n, r, c, p, m, r0, r1, fr, c0, c1, fc;
    logic [63:0]   num, den, top, bot, s, gray;
    noise_result_t res;
    rows = (rows_reg < 1) ? 1 :
           (rows_reg > fvn_pkg::MaxRowsDef) ? fvn_pkg::MaxRowsDef : rows_reg;
    cols = (cols_reg < 1) ? 1 :
           (cols_reg > fvn_pkg::MaxColsDef) ? fvn_pkg::MaxColsDef : cols_reg;
    n    = (octaves_reg < 1) ? 1 :
           (octaves_reg > fvn_pkg::MaxOctavesDef) ? fvn_pkg::MaxOctavesDef : octaves_reg;
    r   = row % rows;
    c   = col % cols;
    num = '0;
    for (int k = 0; k < n; k++) begin
      p  = 1 << k;
      m  = p - 1;
      r0 = r & ~m;
      r1 = (r0 + p) % rows;
      fr = r & m;
      c0 = c & ~m;
      c1 = (c0 + p) % cols;
      fc = c & m;
      top = 64'(grid_model[r0 * fvn_pkg::MaxColsDef + c0]) * (p - fr)
          + 64'(grid_model[r1 * fvn_pkg::MaxColsDef + c0]) * fr;
      bot = 64'(grid_model[r0 * fvn_pkg::MaxColsDef + c1]) * (p - fr)
          + 64'(grid_model[r1 * fvn_pkg::MaxColsDef + c1]) * fr;
      s   = top * (p - fc) + bot * fc;
      num += s << (n - 1 - k);
    end
    den  = (64'd1 << (n - 1)) * ((64'd1 << n) - 1);
    gray = fvn_pkg::GrayBase + (num * fvn_pkg::GrayScale) / (den << fvn_pkg::SampleBitsDef);
    res.noise_value = 16'(num / den);
    res.gray_level  = 8'(gray);
    return res;
  endfunction

  // one input transaction; waits for acceptance and updates the model
  task automatic send_item(input logic op, input logic [5:0] row, input logic [5:0] col,
                           input logic [15:0] smp);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start        = 1'b1;
    in_operation = op;
    in_row       = row;
    in_col       = col;
    in_sample    = smp;
    // busy only moves at rising edges, so the value seen here holds until the next one
    while (busy) @(negedge clk);
    @(posedge clk);
    if (op == fvn_pkg::OpLoad) grid_model[row * fvn_pkg::MaxColsDef + col] = smp;
    else pending_noise = {pending_noise, fractal_noise(row, col)};
    @(negedge clk);
    start = 1'b0;
  endtask

  // wait for every result and for the block to go idle
  task automatic drain;
    while (pending_noise.size() != 0 || busy) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    drain();
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      fvn_pkg::RegRows:    rows_reg    = value[6:0];
      fvn_pkg::RegCols:    cols_reg    = value[6:0];
      fvn_pkg::RegOctaves: octaves_reg = value[3:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(input int rows, input int cols, input int octaves);
    cfg_write(fvn_pkg::RegRows, rows);
    cfg_write(fvn_pkg::RegCols, cols);
    cfg_write(fvn_pkg::RegOctaves, octaves);
  endtask

  // every entry of the sampled area written once, then a few queries over it
  task automatic test_grid_fill;
    for (int i = 0; i < FillRows * FillCols; i++)
      send_item(fvn_pkg::OpLoad, 6'(i / FillCols), 6'(i % FillCols), 16'($urandom));
    set_shape(FillRows, FillCols, 6);
    send_item(fvn_pkg::OpQuery, 6'd0, 6'd0, 16'h0);
    send_item(fvn_pkg::OpQuery, 6'd31, 6'd31, 16'hffff);
    send_item(fvn_pkg::OpQuery, 6'd17, 6'd42, 16'h0);
  endtask

  // field extremes, a saturated corner, wrap and period beyond the grid
  task automatic test_directed_extremes;
    send_item(fvn_pkg::OpLoad, 6'd0, 6'd0, 16'hffff);
    send_item(fvn_pkg::OpLoad, 6'd31, 6'd31, 16'h0000);
    send_item(fvn_pkg::OpLoad, 6'd0, 6'd31, 16'hffff);
    send_item(fvn_pkg::OpLoad, 6'd31, 6'd0, 16'h0001);
    // a load at the far corner of the store, never read back
    send_item(fvn_pkg::OpLoad, 6'd63, 6'd63, 16'h1234);
    set_shape(FillRows, FillCols, 8);
    send_item(fvn_pkg::OpQuery, 6'd0, 6'd0, 16'h0);
    send_item(fvn_pkg::OpQuery, 6'd63, 6'd63, 16'h0);
    send_item(fvn_pkg::OpQuery, 6'd31, 6'd32, 16'h0);
    // one-by-one grid, a single octave: every query wraps to the origin
    set_shape(1, 1, 1);
    send_item(fvn_pkg::OpQuery, 6'd63, 6'd0, 16'h0);
    send_item(fvn_pkg::OpQuery, 6'd0, 6'd63, 16'h0);
    // eight octaves on a small grid: periods beyond the grid size
    set_shape(3, 5, 8);
    send_item(fvn_pkg::OpQuery, 6'd63, 6'd63, 16'h0);
    send_item(fvn_pkg::OpQuery, 6'd2, 6'd4, 16'h0);
    // out-of-range register values saturate
    set_shape(0, 0, 0);
    send_item(fvn_pkg::OpQuery, 6'd5, 6'd9, 16'h0);
    set_shape(100, 65, 1);
    send_item(fvn_pkg::OpQuery, 6'd5, 6'd9, 16'h0);
    send_item(fvn_pkg::OpQuery, 6'd30, 6'd29, 16'h0);
    set_shape(127, 127, 1);
    send_item(fvn_pkg::OpQuery, 6'd0, 6'd30, 16'h0);
    set_shape(7, 32, 15);
    send_item(fvn_pkg::OpQuery, 6'd40, 6'd62, 16'h0);
    set_shape(2, 9, 9);
    send_item(fvn_pkg::OpQuery, 6'd33, 6'd33, 16'h0);
  endtask

  // random transactions over a spread of register settings and idling phases
  task automatic test_random_traffic;
    int idle_phase [3] = '{29, 67, 0};
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = idle_phase[ph];
      for (int blk = 0; blk < 4; blk++) begin
        case ($urandom_range(5))
          0:       set_shape(FillRows, FillCols, 8);
          1:       set_shape(1, FillCols, 1);
          2:       set_shape($urandom_range(FillRows), $urandom_range(FillCols),
                             $urandom_range(15));
          default: set_shape($urandom_range(1, FillRows), $urandom_range(1, FillCols),
                             $urandom_range(1, 8));
        endcase
        for (int i = 0; i < 55; i++) begin
          if ($urandom_range(99) < 40)
            send_item(fvn_pkg::OpLoad, 6'($urandom_range(FillRows - 1)),
                      6'($urandom_range(FillCols - 1)), 16'($urandom));
          else
            send_item(fvn_pkg::OpQuery, 6'($urandom), 6'($urandom), 16'($urandom));
        end
      end
    end
  endtask

  // result checker: a strobe with nothing pending or a wrong field is a mismatch
  always @(posedge clk) begin
    noise_result_t want;
    if (rst_n && out_valid) begin
      if (pending_noise.size() == 0) begin
        $display("%0t: unexpected result noise %0d gray %0d", $time,
                 out_noise_value, out_gray_level);
        mismatches++;
      end else begin
        want = pending_noise.pop_front();
        if (out_noise_value !== want.noise_value) begin
          $display("%0t: noise_value expected %0d actual %0d", $time,
                   want.noise_value, out_noise_value);
          mismatches++;
        end
        if (out_gray_level !== want.gray_level) begin
          $display("%0t: gray_level expected %0d actual %0d", $time,
                   want.gray_level, out_gray_level);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles in which no transaction moves on any channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_operation    = fvn_pkg::OpLoad;
    in_row          = '0;
    in_col          = '0;
    in_sample       = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    mismatches      = 0;
    stall_cycles    = 0;
    sender_idle_pct = 0;
    rows_reg        = fvn_pkg::RowsReset;
    cols_reg        = fvn_pkg::ColsReset;
    octaves_reg     = fvn_pkg::OctavesReset;
    foreach (grid_model[i]) grid_model[i] = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_grid_fill();
    test_directed_extremes();
    test_random_traffic();
    drain();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
